[hdl/rict_pkg.sv]
// ----------------------------------------------------------------------------
// rict_pkg
// Shared types and constants for the inode tag table.
// ----------------------------------------------------------------------------
package rict_pkg;

   localparam int unsigned TABLE_DEPTH_DEF    = 16;
   localparam logic        CACHE_ENABLE_RST   = 1'b1;
   localparam logic [31:0] EXPIRE_TICKS_RST   = 32'd10000;
   localparam int unsigned CSR_INDEX_W        = 4;

   typedef enum logic [2:0] {
      REQ_LOOKUP  = 3'd0,
      REQ_ADD     = 3'd1,
      REQ_RELEASE = 3'd2,
      REQ_DROP    = 3'd3,
      REQ_SYNC    = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_MISS     = 2'd1,
      STS_FULL     = 2'd2,
      STS_DISABLED = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CACHE_ENABLE = 4'd0,
      CSR_EXPIRE_TICKS = 4'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_FINISH,
      ST_RELEASE
   } fsm_type;

   typedef struct packed {
      logic [31:0] tag;
      logic        busy;
      logic [31:0] stamp;
   } entry_type;

endpackage

[hdl/refcount_inode_cache_table_core.sv]
// ----------------------------------------------------------------------------
// refcount_inode_cache_table_core
// Fully associative inode tag table with in-use flags and age-based sync.
// ----------------------------------------------------------------------------
//  channel  ports                 direction  beat
//  req      req_valid/req_ready   in         one request
//  rsp      rsp_valid/rsp_ready   out        one result (sync: several)
//  csr      csr_valid/csr_ready   in         one register write
//
//  Lookup, add and sync walk the slot RAM one entry per cycle unless the
//  walk is stalled on the output register; a hit ends a lookup or add walk early.
//  Reset clears per-slot valid bits; an entry never written reads as empty.
//  A result waiting in the output register stalls the walk only when
//  another result must be produced.
// ----------------------------------------------------------------------------
module refcount_inode_cache_table_core
   import rict_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_type,
   input  logic [31:0]            req_inode_id,
   input  logic [3:0]             req_slot_index,
   input  logic [31:0]            req_now_ticks,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [3:0]             rsp_slot_out,
   output logic                   rsp_flush,
   output logic [31:0]            rsp_flush_inode,
   output logic [4:0]             rsp_flushed_count,
   output logic                   rsp_last,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W  = IDX_W + 1;
   localparam int unsigned ENT_W  = $bits(entry_type);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   fsm_type           state_ff, state_in;
   logic              cache_enable_ff;
   logic [31:0]       expire_ticks_ff;
   logic [TABLE_DEPTH-1:0] vld_ff;

   logic [2:0]        op_ff;
   logic [31:0]       ino_ff;
   logic [3:0]        slot_ff;
   logic [31:0]       now_ff;

   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [3:0]        rsp_slot_ff;
   logic              rsp_flush_ff;
   logic [31:0]       rsp_inode_ff;
   logic [4:0]        rsp_count_ff;
   logic              rsp_last_ff;

   logic              emit;
   status_type        e_status;
   logic [3:0]        e_slot;
   logic              e_flush;
   logic [31:0]       e_inode;
   logic [4:0]        e_count;
   logic              e_last;

   logic              ram_we, ram_re;
   logic [IDX_W-1:0]  ram_waddr, ram_raddr;
   entry_type         ram_wdata;
   logic [ENT_W-1:0]  ram_rdata;
   entry_type         rd_entry;

   logic              out_free;
   logic              slot_in_range;
   logic              is_sync, is_add;
   logic              tag_hit, can_alloc, aged;
   logic [31:0]       age;

   rict_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rd_entry  = vld_ff[chk_idx_ff] ? entry_type'(ram_rdata) : '0;
   assign is_sync   = (op_ff == REQ_SYNC);
   assign is_add    = (op_ff == REQ_ADD);
   assign age       = now_ff - rd_entry.stamp;
   assign aged      = rd_entry.busy && (age >= expire_ticks_ff);
   assign tag_hit   = (rd_entry.tag == ino_ff);
   assign can_alloc = (rd_entry.tag == 32'd0) || !rd_entry.busy;
   assign slot_in_range = ({28'd0, slot_ff} < 32'(TABLE_DEPTH));

   always_comb begin
      state_in      = state_ff;
      rd_cnt_in     = rd_cnt_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      cnt_in        = cnt_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      emit          = 1'b0;
      e_status      = STS_OK;
      e_slot        = '0;
      e_flush       = 1'b0;
      e_inode       = '0;
      e_count       = '0;
      e_last        = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            rd_cnt_in     = '0;
            chk_vld_in    = 1'b0;
            free_found_in = 1'b0;
            cnt_in        = '0;
            if (!cache_enable_ff) begin
               if (out_free) begin
                  emit     = 1'b1;
                  e_status = STS_DISABLED;
                  state_in = ST_IDLE;
               end
            end else begin
               case (op_ff) inside
                  REQ_LOOKUP, REQ_ADD: begin
                     if (ino_ff == 32'd0) begin
                        if (out_free) begin
                           emit     = 1'b1;
                           e_status = STS_MISS;
                           state_in = ST_IDLE;
                        end
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_SYNC: begin
                     state_in = ST_SCAN;
                  end
                  REQ_RELEASE: begin
                     if (!slot_in_range) begin
                        if (out_free) begin
                           emit     = 1'b1;
                           e_status = STS_MISS;
                           state_in = ST_IDLE;
                        end
                     end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = IDX_W'(slot_ff);
                        chk_idx_in = IDX_W'(slot_ff);
                        state_in   = ST_RELEASE;
                     end
                  end
                  REQ_DROP: begin
                     if (out_free) begin
                        emit     = 1'b1;
                        state_in = ST_IDLE;
                        if (!slot_in_range) begin
                           e_status = STS_MISS;
                        end else begin
                           ram_we    = 1'b1;
                           ram_waddr = IDX_W'(slot_ff);
                           e_slot    = slot_ff;
                        end
                     end
                  end
                  default: begin
                     if (out_free) begin
                        emit     = 1'b1;
                        e_status = STS_MISS;
                        state_in = ST_IDLE;
                     end
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (chk_vld_ff && !out_free && (is_sync ? aged : tag_hit)) begin
               // stalled on the output register; hold the walk
            end else begin
               if (rd_cnt_ff != DEPTH_C) begin
                  ram_re     = 1'b1;
                  ram_raddr  = rd_cnt_ff[IDX_W-1:0];
                  chk_vld_in = 1'b1;
                  chk_idx_in = rd_cnt_ff[IDX_W-1:0];
                  rd_cnt_in  = rd_cnt_ff + 1'b1;
               end else begin
                  chk_vld_in = 1'b0;
               end
               if (chk_vld_ff) begin
                  if (is_sync) begin
                     if (aged) begin
                        ram_we         = 1'b1;
                        ram_waddr      = chk_idx_ff;
                        ram_wdata      = rd_entry;
                        ram_wdata.busy = 1'b0;
                        emit           = 1'b1;
                        e_slot         = 4'(chk_idx_ff);
                        e_flush        = 1'b1;
                        e_inode        = rd_entry.tag;
                        e_last         = 1'b0;
                        cnt_in         = cnt_ff + 1'b1;
                     end
                  end else if (tag_hit) begin
                     ram_we          = 1'b1;
                     ram_waddr       = chk_idx_ff;
                     ram_wdata.tag   = rd_entry.tag;
                     ram_wdata.busy  = 1'b1;
                     ram_wdata.stamp = now_ff;
                     emit            = 1'b1;
                     e_slot          = 4'(chk_idx_ff);
                     chk_vld_in      = 1'b0;
                     state_in        = ST_IDLE;
                  end else if (can_alloc && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = chk_idx_ff;
                  end
               end else if (rd_cnt_ff == DEPTH_C) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (is_sync) begin
                  e_count = 5'(cnt_ff);
               end else if (!is_add) begin
                  e_status = STS_MISS;
               end else if (free_found_ff) begin
                  ram_we          = 1'b1;
                  ram_waddr       = free_idx_ff;
                  ram_wdata.tag   = ino_ff;
                  ram_wdata.busy  = 1'b1;
                  ram_wdata.stamp = now_ff;
                  e_slot          = 4'(free_idx_ff);
               end else begin
                  e_status = STS_FULL;
               end
            end
         end

         ST_RELEASE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (rd_entry.tag == 32'd0) begin
                  e_status = STS_MISS;
               end else begin
                  ram_we         = 1'b1;
                  ram_waddr      = chk_idx_ff;
                  ram_wdata      = rd_entry;
                  ram_wdata.busy = 1'b0;
                  e_slot         = slot_ff;
                  e_flush        = 1'b1;
                  e_inode        = rd_entry.tag;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cache_enable_ff <= CACHE_ENABLE_RST;
         expire_ticks_ff <= EXPIRE_TICKS_RST;
         vld_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         chk_vld_ff      <= 1'b0;
         rd_cnt_ff       <= '0;
         free_found_ff   <= 1'b0;
         cnt_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         chk_vld_ff    <= chk_vld_in;
         rd_cnt_ff     <= rd_cnt_in;
         free_found_ff <= free_found_in;
         cnt_ff        <= cnt_in;
         if (ram_we) begin
            vld_ff[ram_waddr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CACHE_ENABLE: cache_enable_ff <= csr_data[0];
               CSR_EXPIRE_TICKS: expire_ticks_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_type;
         ino_ff  <= req_inode_id;
         slot_ff <= req_slot_index;
         now_ff  <= req_now_ticks;
      end
      chk_idx_ff  <= chk_idx_in;
      free_idx_ff <= free_idx_in;
      if (emit) begin
         rsp_status_ff <= e_status;
         rsp_slot_ff   <= e_slot;
         rsp_flush_ff  <= e_flush;
         rsp_inode_ff  <= e_inode;
         rsp_count_ff  <= e_count;
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_out      = rsp_slot_ff;
   assign rsp_flush         = rsp_flush_ff;
   assign rsp_flush_inode   = rsp_inode_ff;
   assign rsp_flushed_count = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef ASSERT_OFF
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re && (ram_waddr == ram_raddr)))
      else $error("slot RAM read and write to the same entry");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= DEPTH_C)
      else $error("slot walk ran past the table");

   a_chk_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> (state_ff == ST_SCAN))
      else $error("check stage live outside the walk");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result beat overwrites a waiting result");

   a_flush_tag: assert property (@(posedge clock) disable iff (reset)
      (emit && e_flush) |=> (rsp_valid && (rsp_flush_inode != 32'd0)))
      else $error("write-back beat for an empty slot");
`endif

endmodule

[hdl/rict_ram.sv]
// ----------------------------------------------------------------------------
// rict_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rict_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the inode tag table core. A queue-fed driver
// offers requests, a clocked predictor tracks tags, in-use flags and access
// stamps, and a monitor checks every result beat in order. Covers directed
// corner cases, register changes at rest and random traffic with
// backpressure.
// ----------------------------------------------------------------------------
module tb_top
   import rict_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int REQ_CODE_MAX = 7;
   localparam int IDLE_PCT     = 24;
   localparam int MAX_REPORTS  = 10;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 24;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] ino;
      logic [3:0]  slot;
      logic [31:0] now;
   } tbl_req_t;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic        flush;
      logic [31:0] ino;
      logic [4:0]  count;
      logic        last;
   } tbl_answer_t;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [2:0]             req_type       = '0;
   logic [31:0]            req_inode_id   = '0;
   logic [3:0]             req_slot_index = '0;
   logic [31:0]            req_now_ticks  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [1:0]             rsp_status;
   logic [3:0]             rsp_slot_out;
   logic                   rsp_flush;
   logic [31:0]            rsp_flush_inode;
   logic [4:0]             rsp_flushed_count;
   logic                   rsp_last;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [31:0]            csr_data       = '0;

   refcount_inode_cache_table_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_inode_id      (req_inode_id),
      .req_slot_index    (req_slot_index),
      .req_now_ticks     (req_now_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_slot_out      (rsp_slot_out),
      .rsp_flush         (rsp_flush),
      .rsp_flush_inode   (rsp_flush_inode),
      .rsp_flushed_count (rsp_flushed_count),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // predictor copy of the table and registers
   logic [31:0] tbl_tag   [DEPTH] = '{default: '0};
   logic        tbl_busy  [DEPTH] = '{default: 1'b0};
   logic [31:0] tbl_stamp [DEPTH] = '{default: '0};
   logic        cfg_enable        = CACHE_ENABLE_RST;
   logic [31:0] cfg_expire        = EXPIRE_TICKS_RST;

   tbl_req_t    request_q [$];
   tbl_answer_t answer_q  [$];
   tbl_req_t    drive_item;
   tbl_req_t    seen_req;
   tbl_answer_t got_beat;
   tbl_answer_t want_beat;

   logic        req_fire     = 1'b0;
   logic        no_idle      = 1'b0;
   int          rx_hold_left = 0;
   logic [31:0] tick_now     = '0;
   int          cycle_count  = 0;
   int          n_errors     = 0;
   int          n_req        = 0;
   int          n_beats      = 0;
   int          n_flush      = 0;
   int          n_full       = 0;
   int          n_miss       = 0;
   int          n_disabled   = 0;
   int          n_sync       = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_answer(input status_type st, input logic [3:0] slot, input logic fl,
                              input logic [31:0] ino, input logic [4:0] cnt,
                              input logic lst);
      tbl_answer_t a;
      a.status = st;
      a.slot   = slot;
      a.flush  = fl;
      a.ino    = ino;
      a.count  = cnt;
      a.last   = lst;
      answer_q.push_back(a);
   endtask

   task automatic predict_table_answer(input tbl_req_t rq);
      int          i;
      int          hit;
      logic        placed;
      logic [4:0]  cnt;
      logic [31:0] age;
      hit    = -1;
      placed = 1'b0;
      cnt    = '0;
      if (!cfg_enable) begin
         push_answer(STS_DISABLED, '0, 1'b0, '0, '0, 1'b1);
         return;
      end
      case (rq.kind) inside
         REQ_LOOKUP, REQ_ADD: begin
            if (rq.ino == '0) begin
               push_answer(STS_MISS, '0, 1'b0, '0, '0, 1'b1);
            end else begin
               for (i = 0; i < DEPTH; i++)
                  if (hit < 0 && tbl_tag[i] == rq.ino) hit = i;
               if (hit >= 0) begin
                  tbl_busy[hit]  = 1'b1;
                  tbl_stamp[hit] = rq.now;
                  push_answer(STS_OK, 4'(hit), 1'b0, '0, '0, 1'b1);
               end else if (rq.kind == REQ_LOOKUP) begin
                  push_answer(STS_MISS, '0, 1'b0, '0, '0, 1'b1);
               end else begin
                  for (i = 0; i < DEPTH; i++) begin
                     if (!placed && (tbl_tag[i] == '0 || !tbl_busy[i])) begin
                        tbl_tag[i]   = rq.ino;
                        tbl_busy[i]  = 1'b1;
                        tbl_stamp[i] = rq.now;
                        placed       = 1'b1;
                        push_answer(STS_OK, 4'(i), 1'b0, '0, '0, 1'b1);
                     end
                  end
                  if (!placed) push_answer(STS_FULL, '0, 1'b0, '0, '0, 1'b1);
               end
            end
         end
         REQ_RELEASE: begin
            if (int'(rq.slot) >= DEPTH || tbl_tag[rq.slot] == '0) begin
               push_answer(STS_MISS, '0, 1'b0, '0, '0, 1'b1);
            end else begin
               tbl_busy[rq.slot] = 1'b0;
               push_answer(STS_OK, rq.slot, 1'b1, tbl_tag[rq.slot], '0, 1'b1);
            end
         end
         REQ_DROP: begin
            if (int'(rq.slot) >= DEPTH) begin
               push_answer(STS_MISS, '0, 1'b0, '0, '0, 1'b1);
            end else begin
               tbl_tag[rq.slot]  = '0;
               tbl_busy[rq.slot] = 1'b0;
               push_answer(STS_OK, rq.slot, 1'b0, '0, '0, 1'b1);
            end
         end
         REQ_SYNC: begin
            for (i = 0; i < DEPTH; i++) begin
               age = rq.now - tbl_stamp[i];
               if (tbl_busy[i] && age >= cfg_expire) begin
                  push_answer(STS_OK, 4'(i), 1'b1, tbl_tag[i], '0, 1'b0);
                  tbl_busy[i] = 1'b0;
                  cnt++;
               end
            end
            push_answer(STS_OK, '0, 1'b0, '0, cnt, 1'b1);
         end
         default: push_answer(STS_MISS, '0, 1'b0, '0, '0, 1'b1);
      endcase
   endtask

   // request acceptance feeds the predictor; result beats are checked in order
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen_req.kind = req_type;
            seen_req.ino  = req_inode_id;
            seen_req.slot = req_slot_index;
            seen_req.now  = req_now_ticks;
            if (req_type == REQ_SYNC) n_sync++;
            n_req++;
            predict_table_answer(seen_req);
         end
         if (rsp_valid && rsp_ready) begin
            got_beat.status = status_type'(rsp_status);
            got_beat.slot   = rsp_slot_out;
            got_beat.flush  = rsp_flush;
            got_beat.ino    = rsp_flush_inode;
            got_beat.count  = rsp_flushed_count;
            got_beat.last   = rsp_last;
            n_beats++;
            if (rsp_flush) n_flush++;
            if (rsp_status == STS_FULL) n_full++;
            if (rsp_status == STS_MISS) n_miss++;
            if (rsp_status == STS_DISABLED) n_disabled++;
            if (answer_q.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_REPORTS)
                  $display("unexpected beat at cycle %0d: %s",
                           cycle_count,
                           $sformatf("st=%0d slot=%0d fl=%0b ino=%h cnt=%0d last=%0b",
                                     rsp_status, rsp_slot_out, rsp_flush,
                                     rsp_flush_inode, rsp_flushed_count, rsp_last));
            end else begin
               want_beat = answer_q.pop_front();
               if (want_beat.status != got_beat.status || want_beat.slot != got_beat.slot ||
                   want_beat.flush != got_beat.flush || want_beat.ino != got_beat.ino ||
                   want_beat.count != got_beat.count || want_beat.last != got_beat.last) begin
                  n_errors++;
                  if (n_errors <= MAX_REPORTS) begin
                     $display("mismatch at cycle %0d", cycle_count);
                     $display("  exp st=%0d slot=%0d fl=%0b ino=%h cnt=%0d last=%0b",
                              want_beat.status, want_beat.slot, want_beat.flush,
                              want_beat.ino, want_beat.count, want_beat.last);
                     $display("  got st=%0d slot=%0d fl=%0b ino=%h cnt=%0d last=%0b",
                              got_beat.status, got_beat.slot, got_beat.flush,
                              got_beat.ino, got_beat.count, got_beat.last);
                  end
               end
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (request_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
            drive_item = request_q.pop_front();
            req_type       <= drive_item.kind;
            req_inode_id   <= drive_item.ino;
            req_slot_index <= drive_item.slot;
            req_now_ticks  <= drive_item.now;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver; a pending hold-off keeps ready low for its full length
   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left = rx_hold_left - 1;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic queue_request(input logic [2:0] kind, input logic [31:0] ino,
                                input logic [3:0] slot, input logic [31:0] now);
      tbl_req_t rq;
      rq.kind = kind;
      rq.ino  = ino;
      rq.slot = slot;
      rq.now  = now;
      request_q.push_back(rq);
   endtask

   function automatic logic [31:0] pick_inode();
      int r;
      r = $urandom_range(99);
      if (r < 4) return '0;
      if (r < 16) return $urandom;
      return 32'($urandom_range(1, 20));
   endfunction

   task automatic queue_random(input int count);
      int         k;
      int         r;
      logic [2:0] kind;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 32)      kind = REQ_ADD;
         else if (r < 52) kind = REQ_LOOKUP;
         else if (r < 66) kind = REQ_RELEASE;
         else if (r < 74) kind = REQ_DROP;
         else if (r < 88) kind = REQ_SYNC;
         else if (r < 92) kind = 3'($urandom_range(int'(REQ_SYNC) + 1, REQ_CODE_MAX));
         else             kind = REQ_LOOKUP;
         if ($urandom_range(99) < 3) tick_now = $urandom;
         else                        tick_now = tick_now + $urandom_range(20);
         queue_request(kind, pick_inode(), 4'($urandom_range(DEPTH - 1)), tick_now);
      end
   endtask

   // distinct new tags, enough to run the table out of free slots
   task automatic queue_fill(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         tick_now = tick_now + 1;
         queue_request(REQ_ADD, {8'(k + 1), 24'($urandom)},
                       4'($urandom_range(DEPTH - 1)), tick_now);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (request_q.size() != 0 || req_valid || answer_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_CACHE_ENABLE) cfg_enable = data[0];
      else                         cfg_expire = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int k;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // directed: zero and all-ones tags, hit paths, expiry boundary, empty slots
      queue_request(REQ_LOOKUP,  32'h0,        4'h0, 32'd0);
      queue_request(REQ_ADD,     32'h0,        4'h0, 32'd0);
      queue_request(REQ_LOOKUP,  32'hFFFFFFFF, 4'h0, 32'd0);
      queue_request(REQ_ADD,     32'hFFFFFFFF, 4'h0, 32'd0);
      queue_request(REQ_ADD,     32'h1,        4'h0, 32'd5);
      queue_request(REQ_LOOKUP,  32'h1,        4'h0, 32'd20000);
      queue_request(REQ_ADD,     32'hFFFFFFFF, 4'h0, 32'd30);
      queue_request(REQ_SYNC,    32'h0,        4'h0, 32'd10029);
      queue_request(REQ_SYNC,    32'h0,        4'h0, 32'd10030);
      queue_request(REQ_RELEASE, 32'h0,        4'h0, 32'd10031);
      queue_request(REQ_RELEASE, 32'h0,        4'hF, 32'd10032);
      queue_request(REQ_RELEASE, 32'h0,        4'h1, 32'd10033);
      queue_request(REQ_DROP,    32'h0,        4'hF, 32'd10034);
      queue_request(REQ_DROP,    32'h0,        4'h0, 32'd10035);
      for (k = int'(REQ_SYNC) + 1; k <= REQ_CODE_MAX; k++)
         queue_request(3'(k), 32'hFFFFFFFF, 4'hF, 32'hFFFFFFFF);
      queue_request(REQ_ADD,     32'h2,        4'h0, 32'hFFFFFFFF);
      queue_request(REQ_ADD,     32'h80000000, 4'h0, 32'd5000);
      queue_request(REQ_SYNC,    32'h0,        4'h0, 32'd10000);
      queue_request(REQ_LOOKUP,  32'h2,        4'h0, 32'd1);
      queue_request(REQ_SYNC,    32'h0,        4'h0, 32'd0);
      wait_drained();

      // zero expiry: every in-use entry goes out on sync; no idling here
      write_csr(CSR_EXPIRE_TICKS, 32'd0);
      @(posedge clock);
      no_idle  = 1'b1;
      tick_now = 32'd100;
      queue_random(40);
      wait_drained();
      no_idle = 1'b0;

      // max expiry, table filled while the receiver holds off
      write_csr(CSR_EXPIRE_TICKS, 32'hFFFFFFFF);
      @(posedge clock);
      rx_hold_left = 400;
      queue_fill(18);
      queue_random(22);
      wait_drained();

      // caching off
      write_csr(CSR_CACHE_ENABLE, 32'd0);
      @(posedge clock);
      queue_random(15);
      wait_drained();

      // back on with a short expiry so sync flushes part of the table
      write_csr(CSR_CACHE_ENABLE, 32'd1);
      write_csr(CSR_EXPIRE_TICKS, 32'($urandom_range(20, 80)));
      @(posedge clock);
      queue_fill(17);
      queue_random(43);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run: %0d requests (%0d syncs), %0d beats checked, %0d errors",
               n_req, n_sync, n_beats, n_errors);
      $display("seen: %0d write-backs, %0d full, %0d miss, %0d disabled",
               n_flush, n_full, n_miss, n_disabled);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[files.f]
hdl/rict_pkg.sv
hdl/rict_ram.sv
hdl/refcount_inode_cache_table_core.sv
tb/tb_top.sv
